@@ design/okvt_pkg.sv @@
// Package with the operation codes, status codes and cell commands of the ordered key/value table.
`default_nettype none
package okvt_pkg;

  localparam logic [2:0] FN_INSERT  = 3'd0;
  localparam logic [2:0] FN_LOOKUP  = 3'd1;
  localparam logic [2:0] FN_REMOVE  = 3'd2;
  localparam logic [2:0] FN_RESET   = 3'd3;
  localparam logic [2:0] FN_ADVANCE = 3'd4;

  localparam logic [2:0] STAT_ADDED     = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_FOUND     = 3'd2;
  localparam logic [2:0] STAT_REMOVED   = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [2:0] STAT_FULL      = 3'd5;
  localparam logic [2:0] STAT_ITER      = 3'd6;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_PROBE  = 3'd1,
    CELL_UPDATE = 3'd2,
    CELL_APPEND = 3'd3,
    CELL_SHIFT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] key;
    logic [31:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ design/ordered_key_value_table.sv @@
// Top level of the ordered key/value table: control sequencer and the chain of slot cells.
// A start transfer runs the probe step, then the execute step, which registers the result strobe.
// A new operation is taken only when idle; busy is high during the probe and execute steps.
// The cells compare the key in the probe step and update, append or shift in the execute step.
// Reset clears the internal entry count, the iterator and the control state; slot contents stay unknown.
// The receiver cannot stall; each result is shown for one cycle.
`default_nettype none
module ordered_key_value_table import okvt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [2:0]                         func,
  input  wire logic signed [31:0]                 key_in,
  input  wire logic [31:0]                        value_in,
  output logic                                    result_valid,
  output logic [2:0]                              status,
  output logic signed [31:0]                      key_out,
  output logic [31:0]                             value_out,
  output logic                                    at_end,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]        entry_count
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [2:0]    op_func;
  logic [31:0]   op_key;
  logic [31:0]   op_value;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;

  cell_cmd_t     cmd;
  logic [IW-1:0] slot;

  logic [31:0] cell_key   [TABLE_DEPTH];
  logic [31:0] cell_value [TABLE_DEPTH];
  logic [31:0] cell_hval  [TABLE_DEPTH];
  logic [31:0] cell_rkey  [TABLE_DEPTH];
  logic [31:0] cell_rval  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_hit;

  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic [31:0]   hit_val;
  logic [31:0]   rd_key_bus;
  logic [31:0]   rd_val_bus;
  logic [CW-1:0] count_dec;

  logic [2:0]    status_next;
  logic [31:0]   key_out_next;
  logic [31:0]   value_out_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      pos          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      pos          <= pos_next;
      result_valid <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_func  <= func;
      op_key   <= key_in;
      op_value <= value_in;
    end
    if (state == S_EXEC) begin
      status      <= status_next;
      key_out     <= key_out_next;
      value_out   <= value_out_next;
      at_end      <= (pos_next == '0);
      entry_count <= count_next;
    end
  end

  always_comb begin
    hit_any    = |cell_hit;
    hit_idx    = '0;
    hit_val    = '0;
    rd_key_bus = '0;
    rd_val_bus = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_idx    = hit_idx | (cell_hit[i] ? IW'(i) : '0);
      hit_val    = hit_val | cell_hval[i];
      rd_key_bus = rd_key_bus | cell_rkey[i];
      rd_val_bus = rd_val_bus | cell_rval[i];
    end
  end

  assign count_dec = count - CW'(1);

  always_comb begin
    state_next     = state;
    count_next     = count;
    pos_next       = pos;
    cmd.op         = CELL_HOLD;
    cmd.key        = op_key;
    cmd.value      = op_value;
    slot           = count[IW-1:0];
    status_next    = STAT_NOT_FOUND;
    key_out_next   = '0;
    value_out_next = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.op     = CELL_PROBE;
        state_next = S_EXEC;
        if (op_func == FN_RESET) begin
          pos_next = (count != '0) ? CW'(1) : '0;
        end else if (op_func == FN_ADVANCE && pos != '0) begin
          pos_next = (pos < count) ? pos + CW'(1) : '0;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (op_func)
          FN_INSERT: begin
            if (hit_any) begin
              cmd.op      = CELL_UPDATE;
              status_next = STAT_UPDATED;
            end else if (count < CW'(TABLE_DEPTH)) begin
              cmd.op      = CELL_APPEND;
              count_next  = count + CW'(1);
              status_next = STAT_ADDED;
            end else begin
              status_next = STAT_FULL;
            end
          end
          FN_LOOKUP: begin
            if (hit_any) begin
              status_next    = STAT_FOUND;
              value_out_next = hit_val;
            end
          end
          FN_REMOVE: begin
            if (hit_any) begin
              cmd.op      = CELL_SHIFT;
              slot        = hit_idx;
              count_next  = count_dec;
              status_next = STAT_REMOVED;
              if (pos != '0 && (CW'(hit_idx) + CW'(1)) < pos) begin
                pos_next = pos - CW'(1);
              end else if (pos != '0 && pos > count_dec) begin
                pos_next = '0;
              end
            end
          end
          FN_RESET, FN_ADVANCE: begin
            status_next    = STAT_ITER;
            key_out_next   = rd_key_bus;
            value_out_next = rd_val_bus;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [31:0] nb_key;
    logic [31:0] nb_value;
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign nb_key   = cell_key[g];
      assign nb_value = cell_value[g];
    end else begin : g_mid
      assign nb_key   = cell_key[g+1];
      assign nb_value = cell_value[g+1];
    end
    okvt_cell #(
      .INDEX (g),
      .IW    (IW),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .slot      (slot),
      .count_lim (count),
      .rd_slot   (IW'(pos - CW'(1))),
      .rd_en     (pos != '0),
      .nb_key    (nb_key),
      .nb_value  (nb_value),
      .key       (cell_key[g]),
      .value     (cell_value[g]),
      .hit       (cell_hit[g]),
      .hit_value (cell_hval[g]),
      .rd_key    (cell_rkey[g]),
      .rd_value  (cell_rval[g])
    );
  end

endmodule
`default_nettype wire

@@ design/okvt_cell.sv @@
// One slot of the table: holds a key and a value, compares, and shifts from its right neighbor.
`default_nettype none
module okvt_cell import okvt_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cell_cmd_t     cmd,
  input  wire logic [IW-1:0] slot,
  input  wire logic [CW-1:0] count_lim,
  input  wire logic [IW-1:0] rd_slot,
  input  wire logic          rd_en,
  input  wire logic [31:0]   nb_key,
  input  wire logic [31:0]   nb_value,
  output logic [31:0]        key,
  output logic [31:0]        value,
  output logic               hit,
  output logic [31:0]        hit_value,
  output logic [31:0]        rd_key,
  output logic [31:0]        rd_value
);

  logic rd_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.op == CELL_PROBE) begin
      hit <= (key == cmd.key) && (CW'(INDEX) < count_lim);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_UPDATE: begin
        if (hit) begin
          value <= cmd.value;
        end
      end
      CELL_APPEND: begin
        if (IW'(INDEX) == slot) begin
          key   <= cmd.key;
          value <= cmd.value;
        end
      end
      CELL_SHIFT: begin
        if (IW'(INDEX) >= slot) begin
          key   <= nb_key;
          value <= nb_value;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_sel    = rd_en && (IW'(INDEX) == rd_slot);
  assign hit_value = hit ? value : 32'd0;
  assign rd_key    = rd_sel ? key : 32'd0;
  assign rd_value  = rd_sel ? value : 32'd0;

endmodule
`default_nettype wire

@@ verif/tb_ordered_key_value_table.sv @@
// Self-checking testbench for the ordered key/value table: random and directed operations.
`default_nettype none
module tb_ordered_key_value_table;
  import okvt_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POOL_N = 24;

  typedef struct {
    logic [2:0]         fn;
    logic signed [31:0] key;
    logic [31:0]        value;
  } table_op_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      key;
    logic [31:0]      value;
    logic             at_end;
    logic [CNT_W-1:0] count;
  } table_reply_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] func = '0;
  logic signed [31:0] key_in = '0;
  logic [31:0] value_in = '0;
  logic busy;
  logic result_valid;
  logic [2:0] status;
  logic signed [31:0] key_out;
  logic [31:0] value_out;
  logic at_end;
  logic [CNT_W-1:0] entry_count;

  table_op_t ops_to_send[$];
  table_reply_t replies_due[$];
  table_op_t next_op;
  table_reply_t want_reply;
  table_reply_t exp_reply;
  table_reply_t got_reply;

  logic [31:0] slot_key[DEPTH];
  logic [31:0] slot_val[DEPTH];
  int held = 0;
  int iter_pos = 0;

  logic [31:0] key_pool[POOL_N];
  int ops_planned = 0;
  int ops_accepted = 0;
  int idle_left = 0;
  int calm_left = 0;
  int idle_roll;
  int errors = 0;

  ordered_key_value_table #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .key_in(key_in),
    .value_in(value_in),
    .result_valid(result_valid),
    .status(status),
    .key_out(key_out),
    .value_out(value_out),
    .at_end(at_end),
    .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic apply_table_op(input table_op_t op, output table_reply_t r);
    int idx;
    idx = -1;
    r = '0;
    r.status = STAT_NOT_FOUND;
    for (int i = held - 1; i >= 0; i--) begin
      if (slot_key[i] == op.key) idx = i;
    end
    case (op.fn)
      FN_INSERT: begin
        if (idx >= 0) begin
          slot_val[idx] = op.value;
          r.status = STAT_UPDATED;
        end else if (held < DEPTH) begin
          slot_key[held] = op.key;
          slot_val[held] = op.value;
          held++;
          r.status = STAT_ADDED;
        end else begin
          r.status = STAT_FULL;
        end
      end
      FN_LOOKUP: begin
        if (idx >= 0) begin
          r.value = slot_val[idx];
          r.status = STAT_FOUND;
        end
      end
      FN_REMOVE: begin
        if (idx >= 0) begin
          for (int i = idx; i + 1 < held; i++) begin
            slot_key[i] = slot_key[i+1];
            slot_val[i] = slot_val[i+1];
          end
          held--;
          // The iterator follows its entry; if removed, it takes the next one or ends.
          if (iter_pos != 0 && idx + 1 < iter_pos) iter_pos--;
          else if (iter_pos != 0 && iter_pos > held) iter_pos = 0;
          r.status = STAT_REMOVED;
        end
      end
      FN_RESET: begin
        iter_pos = (held != 0) ? 1 : 0;
        r.status = STAT_ITER;
      end
      FN_ADVANCE: begin
        if (iter_pos != 0) iter_pos = (iter_pos < held) ? iter_pos + 1 : 0;
        r.status = STAT_ITER;
      end
      default: ;
    endcase
    if (r.status == STAT_ITER && iter_pos != 0) begin
      r.key = slot_key[iter_pos-1];
      r.value = slot_val[iter_pos-1];
    end
    r.at_end = (iter_pos == 0);
    r.count = held[CNT_W-1:0];
  endtask

  task automatic queue_op(input logic [2:0] fn, input logic [31:0] key, input logic [31:0] value);
    table_op_t op;
    op.fn = fn;
    op.key = key;
    op.value = value;
    ops_to_send.push_back(op);
    ops_planned++;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        next_op.fn = func;
        next_op.key = key_in;
        next_op.value = value_in;
        apply_table_op(next_op, want_reply);
        replies_due.push_back(want_reply);
        ops_accepted++;
        if (calm_left > 0) begin
          calm_left--;
          idle_left = 0;
        end else begin
          idle_roll = $urandom_range(0, 99);
          if (idle_roll < 2) calm_left = $urandom_range(20, 60);
          if (idle_roll < 55) idle_left = 0;
          else if (idle_roll < 85) idle_left = $urandom_range(1, 3);
          else if (idle_roll < 97) idle_left = $urandom_range(4, 10);
          else idle_left = $urandom_range(20, 60);
        end
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          next_op = ops_to_send.pop_front();
          func <= next_op.fn;
          key_in <= next_op.key;
          value_in <= next_op.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      got_reply = {status, key_out, value_out, at_end, entry_count};
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result transfer: status %0d key %h value %h", $time,
                 status, key_out, value_out);
        errors++;
      end else begin
        exp_reply = replies_due.pop_front();
        if (got_reply !== exp_reply) begin
          $display("%0t: mismatch expected status %0d key %h value %h at_end %b count %0d",
                   $time, exp_reply.status, exp_reply.key, exp_reply.value,
                   exp_reply.at_end, exp_reply.count);
          $display("%0t:          actual status %0d key %h value %h at_end %b count %0d",
                   $time, got_reply.status, got_reply.key, got_reply.value,
                   got_reply.at_end, got_reply.count);
          errors++;
        end
      end
    end
  end

  initial begin
    int mode;
    int made;
    int roll;
    int ins_w;
    int rem_w;
    int steps;

    // Empty table, missing keys and unused function codes.
    queue_op(FN_RESET, $urandom, $urandom);
    queue_op(FN_ADVANCE, $urandom, $urandom);
    queue_op(FN_LOOKUP, 32'd5, $urandom);
    queue_op(FN_REMOVE, 32'd5, $urandom);
    queue_op(3'd5, $urandom, $urandom);
    queue_op(3'd6, $urandom, $urandom);
    queue_op(3'd7, $urandom, $urandom);
    // Extreme keys and values, then an overwrite and a hit.
    queue_op(FN_INSERT, 32'h8000_0000, 32'h0000_0000);
    queue_op(FN_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_op(FN_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    queue_op(FN_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    queue_op(FN_INSERT, 32'h7FFF_FFFF, 32'h0000_1234);
    queue_op(FN_LOOKUP, 32'h8000_0000, $urandom);
    // Walk the iterator, remove below it and under it, then run past the end.
    queue_op(FN_RESET, $urandom, $urandom);
    queue_op(FN_ADVANCE, $urandom, $urandom);
    queue_op(FN_ADVANCE, $urandom, $urandom);
    queue_op(FN_REMOVE, 32'h8000_0000, $urandom);
    queue_op(FN_REMOVE, 32'h0000_0000, $urandom);
    queue_op(FN_ADVANCE, $urandom, $urandom);
    queue_op(FN_ADVANCE, $urandom, $urandom);
    queue_op(FN_INSERT, 32'h1234_5678, 32'hDEAD_BEEF);
    queue_op(FN_ADVANCE, $urandom, $urandom);
    queue_op(FN_RESET, $urandom, $urandom);
    queue_op(FN_REMOVE, 32'h7FFF_FFFF, $urandom);

    // Segments alternate between filling, mixed traffic and draining the table.
    for (int seg = 0; seg < 11; seg++) begin
      for (int k = 0; k < POOL_N; k++) key_pool[k] = $urandom;
      if (seg % 4 == 0) begin
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
      end
      mode = seg % 3;
      ins_w = (mode == 0) ? 60 : (mode == 1) ? 35 : 20;
      rem_w = (mode == 0) ? 5 : (mode == 1) ? 20 : 40;
      made = 0;
      while (made < 100) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_w) begin
          queue_op(FN_INSERT, pick_key(), $urandom);
          made++;
        end else if (roll < ins_w + rem_w) begin
          queue_op(FN_REMOVE, pick_key(), $urandom);
          made++;
        end else if (roll < ins_w + rem_w + 15) begin
          queue_op(FN_LOOKUP, pick_key(), $urandom);
          made++;
        end else if (roll < ins_w + rem_w + 20) begin
          queue_op(3'($urandom_range(5, 7)), $urandom, $urandom);
          made++;
        end else begin
          steps = $urandom_range(1, 18);
          queue_op(FN_RESET, $urandom, $urandom);
          for (int j = 0; j < steps; j++) begin
            if ($urandom_range(0, 3) == 0) queue_op(FN_REMOVE, pick_key(), $urandom);
            else queue_op(FN_ADVANCE, $urandom, $urandom);
          end
          made += steps + 1;
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (ops_accepted != ops_planned) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
